@@ design/hcpv_pkg.sv @@
`timescale 1ns / 1ps

package hcpv_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_SLOPE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_LEVEL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NIGHT_SETBACK   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOW_MIN        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOW_MAX        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_GAIN   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_START_THRESHOLD = 3'd7;

   // reset values of the registers
   localparam logic [9:0]         RST_CURVE_SLOPE     = 10'd256;
   localparam logic signed [8:0]  RST_CURVE_LEVEL     = 9'sd0;
   localparam logic [8:0]         RST_NIGHT_SETBACK   = 9'd50;
   localparam logic signed [11:0] RST_FLOW_MIN        = 12'sd200;
   localparam logic signed [11:0] RST_FLOW_MAX        = 12'sd450;
   localparam logic [15:0]        RST_PROP_GAIN       = 16'd256;
   localparam logic [15:0]        RST_INTEGRAL_GAIN   = 16'd4;
   localparam logic signed [9:0]  RST_START_THRESHOLD = 10'sd150;

   // valve limits, frost limit, start hysteresis and state reset values
   localparam logic [13:0]        Y_LOW          = 14'd0;
   localparam logic [13:0]        Y_HIGH         = 14'd10000;
   localparam logic [13:0]        Y_RESET        = 14'd5000;
   localparam logic signed [9:0]  FROST_LIMIT    = -10'sd30;
   localparam logic signed [10:0] START_HYST     = 11'sd10;

   // multiplier operand selection
   localparam logic [1:0] MUL_SEL_CURVE = 2'd0;
   localparam logic [1:0] MUL_SEL_GSUM  = 2'd1;
   localparam logic [1:0] MUL_SEL_KP    = 2'd2;

   typedef struct packed {
      logic [9:0]         curve_slope;
      logic signed [8:0]  curve_level;
      logic [8:0]         night_setback;
      logic signed [11:0] flow_min;
      logic signed [11:0] flow_max;
      logic [15:0]        prop_gain;
      logic [15:0]        integral_gain;
      logic signed [9:0]  start_threshold;
   } cfg_type;

   typedef struct packed {
      logic [8:0]         room_setpoint;
      logic signed [9:0]  outside_temp;
      logic signed [9:0]  outside_mean;
      logic signed [11:0] flow_measured;
      logic               reduced_mode;
      logic               party_mode;
      logic               safety_tripped;
   } req_type;

   typedef struct packed {
      logic signed [11:0] flow_setpoint;
      logic [13:0]        valve_position;
      logic               pumps_on;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [1:0] mul_sel;
      logic       mul_en;
      logic       keep_part;
      logic       sum_en;
      logic       clamp_en;
      logic       delta_en;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ design/hcpv_req_if.sv @@
`timescale 1ns / 1ps

interface hcpv_req_if;
   logic               valid;
   logic               ready;
   logic [8:0]         room_setpoint;
   logic signed [9:0]  outside_temp;
   logic signed [9:0]  outside_mean;
   logic signed [11:0] flow_measured;
   logic               reduced_mode;
   logic               party_mode;
   logic               safety_tripped;

   modport source (
      output valid, room_setpoint, outside_temp, outside_mean, flow_measured,
             reduced_mode, party_mode, safety_tripped,
      input  ready
   );

   modport sink (
      input  valid, room_setpoint, outside_temp, outside_mean, flow_measured,
             reduced_mode, party_mode, safety_tripped,
      output ready
   );
endinterface

@@ design/hcpv_rsp_if.sv @@
`timescale 1ns / 1ps

interface hcpv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] flow_setpoint;
   logic [13:0]        valve_position;
   logic               pumps_on;

   modport source (
      output valid, flow_setpoint, valve_position, pumps_on,
      input  ready
   );

   modport sink (
      input  valid, flow_setpoint, valve_position, pumps_on,
      output ready
   );
endinterface

@@ design/hcpv_ctrl.sv @@
`timescale 1ns / 1ps

module hcpv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hcpv_pkg::status_type   status,
   output hcpv_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CURVE = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_MULA  = 3'd4;
   localparam logic [2:0] ST_MULB  = 3'd5;
   localparam logic [2:0] ST_DELTA = 3'd6;
   localparam logic [2:0] ST_POS   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.mul_sel = hcpv_pkg::MUL_SEL_CURVE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CURVE;
            end
         end
         ST_CURVE: begin
            cmd.mul_sel = hcpv_pkg::MUL_SEL_CURVE;
            cmd.mul_en  = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = ST_MULA;
         end
         ST_MULA: begin
            cmd.mul_sel = hcpv_pkg::MUL_SEL_GSUM;
            cmd.mul_en  = 1'b1;
            state_in    = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul_sel   = hcpv_pkg::MUL_SEL_KP;
            cmd.mul_en    = 1'b1;
            cmd.keep_part = 1'b1;
            state_in      = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.delta_en = 1'b1;
            state_in     = ST_POS;
         end
         ST_POS: begin
            // wait here while the previous response is still held
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result stored while output register busy");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_load_starts_curve: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cmd.mul_en && cmd.mul_sel == hcpv_pkg::MUL_SEL_CURVE))
      else $error("curve multiply did not follow load");

endmodule

@@ design/hcpv_dp.sv @@
`timescale 1ns / 1ps

module hcpv_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  hcpv_pkg::cfg_type      cfg,
   input  hcpv_pkg::req_type      req_data,
   input  hcpv_pkg::cmd_type      cmd,
   output hcpv_pkg::status_type   status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output hcpv_pkg::rsp_type      rsp_data
);

   // captured request and early results
   logic [8:0]         room_ff;
   logic signed [11:0] meas_ff;
   logic               setback_on_ff;
   logic               pumps_ff;
   logic               pumps_in;
   logic signed [11:0] diff_ff;
   logic signed [11:0] diff_in;
   logic [16:0]        gsum_ff;

   // shared multiplier
   logic signed [17:0] mul_a;
   logic signed [12:0] mul_b;
   logic signed [30:0] prod_ff;
   logic signed [30:0] prod_in;
   logic signed [30:0] part_ff;

   // setpoint path
   logic signed [30:0] curve_adj;
   logic signed [30:0] curve_quo;
   logic signed [13:0] setback_term;
   logic signed [13:0] sum_ff;
   logic signed [13:0] sum_in;
   logic signed [11:0] sp_ff;
   logic signed [11:0] sp_in;
   logic signed [12:0] err_ff;
   logic signed [12:0] err_in;

   // valve path
   logic signed [30:0] vel_diff;
   logic signed [34:0] vel_wide;
   logic signed [34:0] vel_x10;
   logic signed [34:0] vel_adj;
   logic signed [34:0] vel_quo;
   logic signed [26:0] delta_ff;
   logic signed [26:0] delta_in;
   logic signed [27:0] pos_sum;
   logic [13:0]        pos_in;

   // controller state and output register
   logic signed [12:0] last_err_ff;
   logic [13:0]        last_pos_ff;
   logic               rsp_valid_ff;
   hcpv_pkg::rsp_type  rsp_ff;

   logic signed [10:0] mean_ext;
   logic signed [10:0] start_ext;

   // pump rule, decided when the request is taken
   always_comb begin
      mean_ext  = {req_data.outside_mean[9], req_data.outside_mean};
      start_ext = {cfg.start_threshold[9], cfg.start_threshold};
      if (mean_ext < start_ext || req_data.outside_temp < hcpv_pkg::FROST_LIMIT
          || req_data.party_mode) begin
         pumps_in = 1'b1;
      end else if (mean_ext > start_ext + hcpv_pkg::START_HYST
                   || req_data.safety_tripped) begin
         pumps_in = 1'b0;
      end else begin
         pumps_in = 1'b1;
      end
   end

   assign diff_in = $signed({3'b000, req_data.room_setpoint})
                  - {{2{req_data.outside_temp[9]}}, req_data.outside_temp};

   always_comb begin
      case (cmd.mul_sel)
         hcpv_pkg::MUL_SEL_GSUM: begin
            mul_a = $signed({1'b0, gsum_ff});
            mul_b = err_ff;
         end
         hcpv_pkg::MUL_SEL_KP: begin
            mul_a = $signed({2'b00, cfg.prop_gain});
            mul_b = last_err_ff;
         end
         default: begin
            mul_a = $signed({8'd0, cfg.curve_slope});
            mul_b = {diff_ff[11], diff_ff};
         end
      endcase
      prod_in = 31'(mul_a) * 31'(mul_b);
   end

   // curve: divide by 256 toward zero, then offsets and setback
   always_comb begin
      curve_adj    = prod_ff + (prod_ff[30] ? 31'sd255 : 31'sd0);
      curve_quo    = curve_adj >>> 8;
      setback_term = setback_on_ff ? $signed({5'd0, cfg.night_setback}) : 14'sd0;
      sum_in       = $signed(curve_quo[13:0])
                   + $signed({5'd0, room_ff})
                   + {{5{cfg.curve_level[8]}}, cfg.curve_level}
                   - setback_term;
   end

   // clamp, flow_min tested first
   always_comb begin
      if (sum_ff < $signed({{2{cfg.flow_min[11]}}, cfg.flow_min})) begin
         sp_in = cfg.flow_min;
      end else if (sum_ff > $signed({{2{cfg.flow_max[11]}}, cfg.flow_max})) begin
         sp_in = cfg.flow_max;
      end else begin
         sp_in = sum_ff[11:0];
      end
      err_in = {sp_in[11], sp_in} - {meas_ff[11], meas_ff};
   end

   // velocity step: times 10, divide by 256 toward zero
   always_comb begin
      vel_diff = part_ff - prod_ff;
      vel_wide = {{4{vel_diff[30]}}, vel_diff};
      vel_x10  = (vel_wide <<< 3) + (vel_wide <<< 1);
      vel_adj  = vel_x10 + (vel_x10[34] ? 35'sd255 : 35'sd0);
      vel_quo  = vel_adj >>> 8;
      delta_in = vel_quo[26:0];
   end

   always_comb begin
      pos_sum = $signed({14'd0, last_pos_ff}) + {delta_ff[26], delta_ff};
      if (pos_sum <= $signed({14'd0, hcpv_pkg::Y_LOW})) begin
         pos_in = hcpv_pkg::Y_LOW;
      end else if (pos_sum >= $signed({14'd0, hcpv_pkg::Y_HIGH})) begin
         pos_in = hcpv_pkg::Y_HIGH;
      end else begin
         pos_in = pos_sum[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         room_ff       <= req_data.room_setpoint;
         meas_ff       <= req_data.flow_measured;
         setback_on_ff <= req_data.reduced_mode && !req_data.party_mode;
         pumps_ff      <= pumps_in;
         diff_ff       <= diff_in;
         gsum_ff       <= {1'b0, cfg.prop_gain} + {1'b0, cfg.integral_gain};
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.keep_part) begin
         part_ff <= prod_ff;
      end
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
      if (cmd.clamp_en) begin
         sp_ff  <= sp_in;
         err_ff <= err_in;
      end
      if (cmd.delta_en) begin
         delta_ff <= delta_in;
      end
      if (cmd.finish) begin
         rsp_ff.flow_setpoint  <= sp_ff;
         rsp_ff.valve_position <= pos_in;
         rsp_ff.pumps_on       <= pumps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= 13'sd0;
         last_pos_ff  <= hcpv_pkg::Y_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            last_err_ff  <= err_ff;
            last_pos_ff  <= pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_position_in_limits: assert property (@(posedge clock) disable iff (reset)
      (last_pos_ff >= hcpv_pkg::Y_LOW) && (last_pos_ff <= hcpv_pkg::Y_HIGH))
      else $error("stored valve position outside limits");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish |=> $stable(last_pos_ff) && $stable(last_err_ff))
      else $error("controller state changed without a finished request");

endmodule

@@ design/heating_curve_pi_valve_control.sv @@
`timescale 1ns / 1ps

// weather compensated flow control with a velocity-form pi valve loop.
// each request carries one sample tick: room setpoint, outside and mean
// outside temperature (tenths of a degree), measured flow temperature and
// the mode bits. the response gives the clamped flow setpoint, the valve
// position in 0.01 % units and the pump command. a request runs through a
// fixed sequence of 8 steps: load at the accepting edge, curve multiply,
// curve sum, setpoint clamp, two gain multiplies on one shared 18 x 13
// multiplier, delta scaling and the position update, which loads the response
// register. the next request can be taken the cycle after that, and not
// before: one request is in flight at a time. the response sits in its own
// register, and the sequencer only waits in its last step when that register
// still holds an untaken response. the valve position and the last flow
// error are kept between requests and reset to 50 % and zero. registers
// are written through the csr port; the user must write them only while
// no request is in flight, the block itself does not enforce it.

module heating_curve_pi_valve_control (
   input  logic                                clock,
   input  logic                                reset,
   hcpv_req_if.sink                            req_chan,
   hcpv_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [hcpv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hcpv_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hcpv_pkg::cfg_type     cfg_ff;
   hcpv_pkg::cfg_type     cfg_in;
   hcpv_pkg::req_type     req_data;
   hcpv_pkg::rsp_type     rsp_data;
   hcpv_pkg::cmd_type     cmd;
   hcpv_pkg::status_type  status;
   logic                  req_ready;
   logic                  rsp_valid;

   // register file: each write lands in the register its index names
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            hcpv_pkg::REG_CURVE_SLOPE:     cfg_in.curve_slope     = csr_wdata[9:0];
            hcpv_pkg::REG_CURVE_LEVEL:     cfg_in.curve_level     = $signed(csr_wdata[8:0]);
            hcpv_pkg::REG_NIGHT_SETBACK:   cfg_in.night_setback   = csr_wdata[8:0];
            hcpv_pkg::REG_FLOW_MIN:        cfg_in.flow_min        = $signed(csr_wdata[11:0]);
            hcpv_pkg::REG_FLOW_MAX:        cfg_in.flow_max        = $signed(csr_wdata[11:0]);
            hcpv_pkg::REG_PROP_GAIN:       cfg_in.prop_gain       = csr_wdata[15:0];
            hcpv_pkg::REG_INTEGRAL_GAIN:   cfg_in.integral_gain   = csr_wdata[15:0];
            hcpv_pkg::REG_START_THRESHOLD: cfg_in.start_threshold = $signed(csr_wdata[9:0]);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_slope     <= hcpv_pkg::RST_CURVE_SLOPE;
         cfg_ff.curve_level     <= hcpv_pkg::RST_CURVE_LEVEL;
         cfg_ff.night_setback   <= hcpv_pkg::RST_NIGHT_SETBACK;
         cfg_ff.flow_min        <= hcpv_pkg::RST_FLOW_MIN;
         cfg_ff.flow_max        <= hcpv_pkg::RST_FLOW_MAX;
         cfg_ff.prop_gain       <= hcpv_pkg::RST_PROP_GAIN;
         cfg_ff.integral_gain   <= hcpv_pkg::RST_INTEGRAL_GAIN;
         cfg_ff.start_threshold <= hcpv_pkg::RST_START_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request payload into one bundle for the datapath
   assign req_data.room_setpoint  = req_chan.room_setpoint;
   assign req_data.outside_temp   = req_chan.outside_temp;
   assign req_data.outside_mean   = req_chan.outside_mean;
   assign req_data.flow_measured  = req_chan.flow_measured;
   assign req_data.reduced_mode   = req_chan.reduced_mode;
   assign req_data.party_mode     = req_chan.party_mode;
   assign req_data.safety_tripped = req_chan.safety_tripped;
   assign req_chan.ready          = req_ready;

   // sequencer: steps the datapath through one request
   hcpv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: curve, clamp, shared multiplier, pi step, response register
   hcpv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.flow_setpoint  = rsp_data.flow_setpoint;
   assign rsp_chan.valve_position = rsp_data.valve_position;
   assign rsp_chan.pumps_on       = rsp_data.pumps_on;

endmodule
